// ----- rtl/sactl_pkg.sv -----
// Shared types and constants for the cache tag lookup core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sactl_pkg;

  localparam int SET_IDX_W = 6;
  localparam int TAG_IN_W  = 20;
  localparam int OUT_WAY_W = 2;
  localparam int TAG_OUT_W = 20;
  localparam int POLICY_W  = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // replacement policy codes; the unused codes behave as random
  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd1;

  // register index, decoded from paddr[2]
  localparam logic REG_POLICY = 1'b0;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef struct packed {
    logic [SET_IDX_W-1:0] set_index;
    logic [TAG_IN_W-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 evicted;
    logic [TAG_OUT_W-1:0] evicted_tag;
  } res_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

// ----- rtl/set_assoc_cache_tag_lookup_core.sv -----
// Set-associative cache tag lookup. One access per cycle while busy is low; the result
// strobe is registered after the lookup stage (set memory read, then compare/update).
// Same-set accesses in consecutive cycles are forwarded from the last write-back.
// After reset, busy stays high while the set memory is cleared;
// policy resets to LRU and the victim LFSR to 0xACE1. Results cannot be stalled.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_core import sactl_pkg::*; #(
  parameter int SETS     = 64,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cmd_t                cmd_i,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = $clog2(WAYS + 1);
  localparam int ROW_W  = WAYS * (1 + RANK_W + TAG_BITS);
  localparam int IDX_N  = 1 << SET_IDX_W;
  localparam int BYTE_R = 256 % WAYS;

  // constant tables: set index modulo SETS, byte value modulo WAYS
  logic [SET_W-1:0] set_tab [IDX_N];
  logic [WAY_W-1:0] mod_tab [256];

  for (genvar g = 0; g < IDX_N; g++) begin : g_set_tab
    assign set_tab[g] = SET_W'(g % SETS);
  end
  for (genvar g = 0; g < 256; g++) begin : g_mod_tab
    assign mod_tab[g] = WAY_W'(g % WAYS);
  end

  logic [POLICY_W-1:0] policy;

  sactl_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .policy_o (policy)
  );

  // clear pass
  logic             clr_active_q, clr_active_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;

  // accept stage
  logic              acc;
  logic [SET_W-1:0]  acc_set;
  logic [15:0]       lfsr_q, lfsr_d;
  logic [15:0]       lfsr_nx;

  // lookup stage
  logic                s1_valid_q, s1_valid_d;
  logic [SET_W-1:0]    s1_set_q;
  logic [TAG_BITS-1:0] s1_tag_q;
  logic [WAY_W-1:0]    s1_ra_q;
  logic [WAY_W-1:0]    s1_rb_q;
  logic [7:0]          rnd_idx;
  logic [WAY_W-1:0]    rnd_way;

  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  logic [WAYS-1:0]               cur_valid, new_valid;
  logic [WAYS-1:0][RANK_W-1:0]   cur_rank, new_rank;
  logic [WAYS-1:0][TAG_BITS-1:0] cur_tags, new_tags;
  res_t                          res_word;

  // last write-back, for read-during-write on the same set
  logic             fwd_valid_q, fwd_valid_d;
  logic [SET_W-1:0] fwd_set_q;
  logic [ROW_W-1:0] fwd_row_q;

  logic res_valid_q, res_valid_d;
  res_t res_q;

  assign busy    = clr_active_q;
  assign acc     = start & ~clr_active_q;
  assign acc_set = set_tab[cmd_i.set_index];
  assign lfsr_nx = lfsr_next(lfsr_q);

  sactl_set_ram #(
    .DEPTH  (SETS),
    .WIDTH  (ROW_W),
    .ADDR_W (SET_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc),
    .raddr_i (acc_set),
    .rdata_o (ram_rdata)
  );

  assign row_cur = (fwd_valid_q && (fwd_set_q == s1_set_q)) ? fwd_row_q : ram_rdata;
  assign {cur_valid, cur_rank, cur_tags} = row_cur;

  // lfsr mod WAYS = (hi mod W)*(256 mod W) + (lo mod W), reduced once more
  assign rnd_idx = 8'(s1_ra_q) * 8'(BYTE_R) + 8'(s1_rb_q);
  assign rnd_way = mod_tab[rnd_idx];

  sactl_way_logic #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS),
    .RANK_W   (RANK_W),
    .WAY_W    (WAY_W)
  ) u_way (
    .policy_i  (policy),
    .tag_i     (s1_tag_q),
    .rnd_way_i (rnd_way),
    .valid_i   (cur_valid),
    .rank_i    (cur_rank),
    .tags_i    (cur_tags),
    .valid_o   (new_valid),
    .rank_o    (new_rank),
    .tags_o    (new_tags),
    .res_o     (res_word)
  );

  assign row_new   = {new_valid, new_rank, new_tags};
  assign ram_we    = clr_active_q | s1_valid_q;
  assign ram_waddr = clr_active_q ? clr_cnt_q : s1_set_q;
  assign ram_wdata = clr_active_q ? '0 : row_new;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SET_W'(SETS - 1)) begin
        clr_active_d = 1'b0;
      end
    end
    lfsr_d      = acc ? lfsr_nx : lfsr_q;
    s1_valid_d  = acc;
    fwd_valid_d = fwd_valid_q | s1_valid_q;
    res_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      lfsr_q       <= LFSR_SEED;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      lfsr_q       <= lfsr_d;
      s1_valid_q   <= s1_valid_d;
      fwd_valid_q  <= fwd_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_set_q <= acc_set;
      s1_tag_q <= TAG_BITS'(cmd_i.tag);
      s1_ra_q  <= mod_tab[lfsr_nx[15:8]];
      s1_rb_q  <= mod_tab[lfsr_nx[7:0]];
    end
    if (s1_valid_q) begin
      fwd_set_q <= s1_set_q;
      fwd_row_q <= row_new;
      res_q     <= res_word;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // no lookup may be in flight while the clear pass owns the write port
  a_clr_no_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q && !res_valid_q)
    else $error("lookup active during clear pass");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> res_valid_q && fwd_valid_q)
    else $error("lookup did not produce a result word");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.hit && res_q.evicted))
    else $error("hit reported with eviction");

  a_evtag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.evicted) |-> (res_q.evicted_tag == '0))
    else $error("evicted tag nonzero without eviction");

endmodule

// ----- rtl/sactl_cfg_regs.sv -----
// APB-style register port holding the replacement policy.
// Depends on sactl_pkg.
`timescale 1ns / 1ps

module sactl_cfg_regs import sactl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [POLICY_W-1:0] policy_o
);

  logic [POLICY_W-1:0] policy_q, policy_d;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_POLICY);

  always_comb begin
    policy_d = policy_q;
    if (wr_en) begin
      policy_d = pwdata[POLICY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_LRU;
    end else begin
      policy_q <= policy_d;
    end
  end

  assign prdata   = (paddr[2] == REG_POLICY) ? PDATA_W'(policy_q) : '0;
  assign policy_o = policy_q;

endmodule

// ----- rtl/sactl_set_ram.sv -----
// Set memory: one row per set holding valid bits, ranks and tags of all ways.
// One write port, one read port, read data registered. Depends on sactl_pkg.
`timescale 1ns / 1ps

module sactl_set_ram import sactl_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 96,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-row collision; the core forwards around it
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sactl_way_logic.sv -----
// Tag compare, victim choice and rank update for one set row.
// Purely combinational; depends on sactl_pkg.
`timescale 1ns / 1ps

module sactl_way_logic import sactl_pkg::*; #(
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20,
  parameter int RANK_W   = 3,
  parameter int WAY_W    = 2
) (
  input  logic [POLICY_W-1:0]            policy_i,
  input  logic [TAG_BITS-1:0]            tag_i,
  input  logic [WAY_W-1:0]               rnd_way_i,
  input  logic [WAYS-1:0]                valid_i,
  input  logic [WAYS-1:0][RANK_W-1:0]    rank_i,
  input  logic [WAYS-1:0][TAG_BITS-1:0]  tags_i,
  output logic [WAYS-1:0]                valid_o,
  output logic [WAYS-1:0][RANK_W-1:0]    rank_o,
  output logic [WAYS-1:0][TAG_BITS-1:0]  tags_o,
  output res_t                           res_o
);

  localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(WAYS);

  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   min_vec;
  logic              found;
  logic              have_inv;
  logic              rand_pol;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  min_way;
  logic [WAY_W-1:0]  victim;
  logic [WAY_W-1:0]  out_way;
  logic [RANK_W-1:0] hit_rank;

  always_comb begin
    rand_pol = !((policy_i == POL_LRU) || (policy_i == POL_FIFO));

    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = valid_i[i] && (tags_i[i] == tag_i);
      // oldest way: strictly below earlier ways, not above later ones
      min_vec[i] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < i) begin
          min_vec[i] = min_vec[i] && (rank_i[i] < rank_i[j]);
        end else if (j > i) begin
          min_vec[i] = min_vec[i] && (rank_i[i] <= rank_i[j]);
        end
      end
    end

    found    = |hit_vec;
    have_inv = !(&valid_i);
    hit_way  = '0;
    inv_way  = '0;
    min_way  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (!valid_i[i]) begin
        inv_way = WAY_W'(i);
      end
      if (min_vec[i]) begin
        min_way = WAY_W'(i);
      end
    end

    if (have_inv) begin
      victim = inv_way;
    end else if (rand_pol) begin
      victim = rnd_way_i;
    end else begin
      victim = min_way;
    end

    hit_rank = rank_i[hit_way];
    valid_o  = valid_i;
    rank_o   = rank_i;
    tags_o   = tags_i;

    if (found) begin
      if (policy_i == POL_LRU) begin
        for (int i = 0; i < WAYS; i++) begin
          if (rank_i[i] > hit_rank) begin
            rank_o[i] = rank_i[i] - 1'b1;
          end
        end
        rank_o[hit_way] = TOP_RANK;
      end
    end else begin
      if (!rand_pol) begin
        for (int i = 0; i < WAYS; i++) begin
          if ((WAY_W'(i) != victim) && valid_i[i] && (rank_i[i] != '0)) begin
            rank_o[i] = rank_i[i] - 1'b1;
          end
        end
        rank_o[victim] = TOP_RANK;
      end
      tags_o[victim]  = tag_i;
      valid_o[victim] = 1'b1;
    end

    out_way           = found ? hit_way : victim;
    res_o.hit         = found;
    res_o.way         = OUT_WAY_W'(out_way);
    res_o.evicted     = !found && !have_inv;
    res_o.evicted_tag = (!found && !have_inv) ? TAG_OUT_W'(tags_i[victim]) : '0;
  end

endmodule
